>>> hw/rtl/spc_pkg.sv
package spc_pkg;

  typedef struct packed {
    logic               trig_high;
    logic signed [23:0] step_rate;
    logic [7:0]         start_segment;
    logic [31:0]        start_position;
    logic               loop_on;
  } req_t;

  typedef struct packed {
    logic [7:0]         even_segment;
    logic [31:0]        even_position;
    logic [7:0]         odd_segment;
    logic [31:0]        odd_position;
    logic signed [15:0] crossfade;
    logic               is_running;
  } rsp_t;

  typedef struct packed {
    logic [23:0] overlap_len;
    logic [7:0]  begin_segment;
    logic [31:0] begin_position;
    logic [7:0]  end_segment;
    logic [31:0] end_position;
  } cfg_t;

  typedef enum logic [1:0] {
    HOLD_RUN   = 2'd0,
    HOLD_BEGIN = 2'd1,
    HOLD_END   = 2'd2
  } hold_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_XF,
    S_ADV,
    S_CARRY,
    S_ENDCHK,
    S_BEGCHK,
    S_COMMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic xf;
    logic adv;
    logic carry;
    logic endchk;
    logic begchk;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  localparam logic [2:0] CFG_OVERLAP_LEN    = 3'd0;
  localparam logic [2:0] CFG_BEGIN_SEGMENT  = 3'd1;
  localparam logic [2:0] CFG_BEGIN_POSITION = 3'd2;
  localparam logic [2:0] CFG_END_SEGMENT    = 3'd3;
  localparam logic [2:0] CFG_END_POSITION   = 3'd4;

  localparam logic [4:0]  DIV_STEPS = 5'd17;
  localparam logic [16:0] RAMP_FULL = 17'd32768;
  localparam logic signed [17:0] XF_FULL = 18'sd16384;

endpackage

>>> hw/rtl/segmented_phasor_crossfade.sv
// Segmented phasor with crossfade, one request per audio sample.
// A request carries the trigger level, the signed rate, the start point and
// the loop flag. Each request produces exactly one result on the output
// channel: segment and position for the even and odd player channels, the
// Q2.14 crossfade and the running flag, all describing the state before the
// position advances.
// The configuration port writes overlap, begin and end bounds; the user must
// write it only while no request is in flight, as the block does not enforce it.
// A request is accepted when req_valid is high and req_stall is low. Its
// result passes through preparation, a 17-step serial divider for the
// crossfade ramp, the crossfade step and the position update (advance,
// carry, end check, begin check, commit) before it is loaded into the output
// register; the next request is taken only after that load.
// While rsp_stall holds a result, the next request is still accepted and
// processed; its result waits in the block until the output register frees.
// Reset clears the play state, the trigger history and all configuration
// registers to their defaults, and empties the output register.
module segmented_phasor_crossfade #(
  parameter int SEGMENT_LENGTH = 16777216,
  parameter int MAX_SEGMENTS   = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spc_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import spc_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overlap_len    <= '0;
      cfg.begin_segment  <= '0;
      cfg.begin_position <= '0;
      cfg.end_segment    <= 8'hFF;
      cfg.end_position   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OVERLAP_LEN:    cfg.overlap_len    <= cfg_data[23:0];
        CFG_BEGIN_SEGMENT:  cfg.begin_segment  <= cfg_data[7:0];
        CFG_BEGIN_POSITION: cfg.begin_position <= cfg_data;
        CFG_END_SEGMENT:    cfg.end_segment    <= cfg_data[7:0];
        CFG_END_POSITION:   cfg.end_position   <= cfg_data;
        default: ;
      endcase
    end
  end

  spc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spc_dpath #(
    .SEGMENT_LENGTH (SEGMENT_LENGTH),
    .MAX_SEGMENTS   (MAX_SEGMENTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> hw/rtl/spc_ctrl.sv
module spc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  spc_pkg::stat_t stat,
  output spc_pkg::cmd_t  cmd
);
  import spc_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [4:0] div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_PREP) begin
        div_cnt <= '0;
      end else if (state == S_DIV) begin
        div_cnt <= div_cnt + 5'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_valid) state_next = S_PREP;
      S_PREP:   state_next = S_DIV;
      S_DIV:    if (div_cnt == DIV_STEPS - 5'd1) state_next = S_XF;
      S_XF:     state_next = S_ADV;
      S_ADV:    state_next = S_CARRY;
      S_CARRY:  state_next = S_ENDCHK;
      S_ENDCHK: state_next = S_BEGCHK;
      S_BEGCHK: state_next = S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_OUT:    if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      S_PREP:   cmd.prep = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_XF:     cmd.xf = 1'b1;
      S_ADV:    cmd.adv = 1'b1;
      S_CARRY:  cmd.carry = 1'b1;
      S_ENDCHK: cmd.endchk = 1'b1;
      S_BEGCHK: cmd.begchk = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_OUT:    cmd.out_load = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

>>> hw/rtl/spc_dpath.sv
module spc_dpath #(
  parameter int SEGMENT_LENGTH = 16777216,
  parameter int MAX_SEGMENTS   = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  spc_pkg::cfg_t  cfg,
  input  spc_pkg::req_t  req,
  input  spc_pkg::cmd_t  cmd,
  output spc_pkg::stat_t stat,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output spc_pkg::rsp_t  rsp
);
  import spc_pkg::*;

  localparam logic [24:0] SEG_LEN = 25'(SEGMENT_LENGTH);
  localparam logic [23:0] OV_MAX  = 24'(SEGMENT_LENGTH - 1);
  localparam logic [7:0]  SEG_MAX = 8'(MAX_SEGMENTS - 1);

  logic               last_trig;
  logic [7:0]         seg;
  logic [31:0]        pos;
  hold_t              hold;

  logic signed [23:0] rate_q;
  logic               loop_q;
  logic               ovl;
  logic               seg_even;
  logic               div_sat;
  logic [25:0]        rem;
  logic [16:0]        nlow;
  logic [16:0]        quo;
  logic               wrun;
  logic signed [9:0]  wseg;
  logic signed [35:0] wpos;
  rsp_t               r;

  logic [23:0]        ov;
  logic [31:0]        ovq;
  logic [32:0]        spacing;
  logic [7:0]         bseg;
  logic [7:0]         eseg;
  logic [7:0]         sseg;
  logic [23:0]        d;
  logic [24:0]        dd;
  logic [40:0]        num;
  logic [25:0]        rem_sh;
  logic               rem_ge;
  logic [16:0]        ramp;
  logic signed [17:0] xf_even;
  logic signed [35:0] sp36;
  logic signed [35:0] bpos36;
  logic signed [35:0] epos36;
  logic signed [9:0]  bseg10;
  logic signed [9:0]  eseg10;
  logic               end_hit;
  logic               beg_hit;

  always_comb begin
    ov      = (cfg.overlap_len > OV_MAX) ? OV_MAX : cfg.overlap_len;
    ovq     = {ov, 8'h00};
    spacing = {SEG_LEN - {1'b0, ov}, 8'h00};
    bseg    = (cfg.begin_segment > SEG_MAX) ? SEG_MAX : cfg.begin_segment;
    eseg    = (cfg.end_segment > SEG_MAX) ? SEG_MAX : cfg.end_segment;
    sseg    = (req.start_segment > SEG_MAX) ? SEG_MAX : req.start_segment;
    d       = ov - 24'd1;
    dd      = {d, 1'b0};
    num     = {1'b0, pos, 8'h00} + {17'd0, d};
    rem_sh  = {rem[24:0], nlow[16]};
    rem_ge  = rem_sh >= {1'b0, dd};
    ramp    = (div_sat || quo > RAMP_FULL) ? RAMP_FULL : quo;
    xf_even = XF_FULL - signed'({1'b0, ramp});
    sp36    = signed'({3'b000, spacing});
    bpos36  = signed'({4'h0, cfg.begin_position});
    epos36  = signed'({4'h0, cfg.end_position});
    bseg10  = signed'({2'b00, bseg});
    eseg10  = signed'({2'b00, eseg});
    end_hit = (wseg == eseg10 && wpos >= epos36) || (wseg > eseg10);
    beg_hit = (wseg == bseg10 && wpos <= bpos36) || (wseg < bseg10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_trig <= 1'b0;
      seg       <= '0;
      pos       <= '0;
      hold      <= HOLD_RUN;
    end else begin
      if (cmd.capture) begin
        last_trig <= req.trig_high;
        if (!last_trig && req.trig_high) begin
          seg  <= sseg;
          pos  <= req.start_position;
          hold <= HOLD_RUN;
        end
      end
      if (cmd.prep) begin
        if (hold == HOLD_BEGIN && rate_q > 24'sd0) begin
          hold <= HOLD_RUN;
        end
        if (hold == HOLD_END && rate_q < 24'sd0) begin
          hold <= HOLD_RUN;
        end
      end
      if (cmd.endchk && end_hit && !loop_q) begin
        hold <= HOLD_END;
      end
      if (cmd.begchk && beg_hit && !loop_q) begin
        hold <= HOLD_BEGIN;
      end
      if (cmd.commit) begin
        if (wpos < 36'sd0) begin
          pos <= '0;
        end else if (wpos > 36'sh0FFFFFFFF) begin
          pos <= '1;
        end else begin
          pos <= wpos[31:0];
        end
        if (wseg < 10'sd0) begin
          seg <= '0;
        end else if (wseg > signed'({2'b00, SEG_MAX})) begin
          seg <= SEG_MAX;
        end else begin
          seg <= wseg[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rate_q <= req.step_rate;
      loop_q <= req.loop_on;
    end
    if (cmd.prep) begin
      seg_even     <= ~seg[0];
      ovl          <= (pos < ovq) && (seg != 8'd0);
      div_sat      <= (ov <= 24'd1) || ({1'b0, num[40:17]} >= dd);
      rem          <= {2'b00, num[40:17]};
      nlow         <= num[16:0];
      quo          <= '0;
      r.is_running <= (hold == HOLD_RUN);
      if (pos < ovq && seg != 8'd0) begin
        if (!seg[0]) begin
          r.even_segment  <= seg;
          r.even_position <= pos;
          r.odd_segment   <= seg - 8'd1;
          r.odd_position  <= spacing[31:0] + pos;
        end else begin
          r.odd_segment   <= seg;
          r.odd_position  <= pos;
          r.even_segment  <= seg - 8'd1;
          r.even_position <= spacing[31:0] + pos;
        end
      end else if (!seg[0]) begin
        r.even_segment  <= seg;
        r.even_position <= pos;
        r.odd_segment   <= '0;
        r.odd_position  <= '0;
      end else begin
        r.odd_segment   <= seg;
        r.odd_position  <= pos;
        r.even_segment  <= '0;
        r.even_position <= '0;
      end
    end
    if (cmd.div_step) begin
      rem  <= rem_ge ? (rem_sh - {1'b0, dd}) : rem_sh;
      nlow <= {nlow[15:0], 1'b0};
      quo  <= {quo[15:0], rem_ge};
    end
    if (cmd.xf) begin
      if (!ovl) begin
        r.crossfade <= seg_even ? -16'sd16384 : 16'sd16384;
      end else if (seg_even) begin
        r.crossfade <= xf_even[15:0];
      end else begin
        r.crossfade <= 16'(-xf_even);
      end
    end
    if (cmd.adv) begin
      wrun <= (hold == HOLD_RUN);
      wseg <= signed'({2'b00, seg});
      if (hold == HOLD_RUN) begin
        wpos <= signed'({4'h0, pos}) + 36'(rate_q);
      end else begin
        wpos <= signed'({4'h0, pos});
      end
    end
    if (cmd.carry && wrun) begin
      if (wpos >= sp36) begin
        wpos <= wpos - sp36;
        wseg <= wseg + 10'sd1;
      end else if (wpos < 36'sd0) begin
        wpos <= wpos + sp36;
        wseg <= wseg - 10'sd1;
      end
    end
    if (cmd.endchk && end_hit) begin
      if (loop_q) begin
        wseg <= bseg10;
        wpos <= wpos - epos36 + bpos36;
      end else begin
        wseg <= eseg10;
        wpos <= epos36;
      end
    end
    if (cmd.begchk && beg_hit) begin
      if (loop_q) begin
        wseg <= eseg10;
        wpos <= wpos - bpos36 + epos36;
      end else begin
        wseg <= bseg10;
        wpos <= bpos36;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp <= r;
    end
  end

  assign stat.out_free = !rsp_valid || !rsp_stall;

endmodule

>>> sim/segmented_phasor_crossfade_tb.sv
`timescale 1ns / 1ps

module testbench;
  import spc_pkg::*;

  localparam longint SEG_LEN = 64'd16777216;
  localparam longint TOP_SEG = 64'd255;
  localparam longint XF_ONE = 64'd16384;
  localparam int QUIET_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_OVERLAP_LEN;
  logic [31:0] cfg_data = '0;

  segmented_phasor_crossfade dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t sample_queue[$];
  rsp_t frames_due[$];
  int queued_items = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  cfg_t regs;
  logic last_trig = 1'b0;
  logic [7:0] play_seg = '0;
  logic [31:0] play_pos = '0;
  hold_t play_hold = HOLD_RUN;

  function automatic rsp_t advance_phasor(input req_t r);
    rsp_t o;
    longint ov, ovq, span, rate, seg, pos, ramp, d, xf, oth_seg, oth_pos;
    longint bseg, bpos, eseg, epos;
    logic even;
    ov = regs.overlap_len;
    if (ov > SEG_LEN - 1) ov = SEG_LEN - 1;
    ovq = ov <<< 8;
    span = (SEG_LEN - ov) <<< 8;
    rate = $signed(r.step_rate);
    bseg = regs.begin_segment;
    bpos = regs.begin_position;
    eseg = regs.end_segment;
    epos = regs.end_position;

    if (!last_trig && r.trig_high) begin
      play_seg = r.start_segment;
      play_pos = r.start_position;
      play_hold = HOLD_RUN;
    end
    last_trig = r.trig_high;

    seg = play_seg;
    pos = play_pos;
    even = (seg % 2) == 0;
    oth_seg = 0;
    oth_pos = 0;
    if (pos >= ovq || seg == 0) begin
      xf = even ? -XF_ONE : XF_ONE;
    end else begin
      oth_seg = seg - 1;
      oth_pos = span + pos;
      if (ov <= 1) begin
        ramp = 2 * XF_ONE;
      end else begin
        d = ov - 1;
        ramp = (pos * 256 + d) / (2 * d);
        if (ramp > 2 * XF_ONE) ramp = 2 * XF_ONE;
      end
      xf = even ? XF_ONE - ramp : ramp - XF_ONE;
    end
    o.even_segment = 8'(even ? seg : oth_seg);
    o.even_position = 32'(even ? pos : oth_pos);
    o.odd_segment = 8'(even ? oth_seg : seg);
    o.odd_position = 32'(even ? oth_pos : pos);
    o.crossfade = 16'(xf);
    o.is_running = (play_hold == HOLD_RUN);

    if (play_hold == HOLD_BEGIN && rate > 0) play_hold = HOLD_RUN;
    if (play_hold == HOLD_END && rate < 0) play_hold = HOLD_RUN;
    if (play_hold == HOLD_RUN) begin
      pos += rate;
      if (pos >= span) begin
        pos -= span;
        seg++;
      end
      if (pos < 0) begin
        pos += span;
        seg--;
      end
    end
    if ((seg == eseg && pos >= epos) || seg > eseg) begin
      if (r.loop_on) begin
        seg = bseg;
        pos = pos - epos + bpos;
      end else begin
        seg = eseg;
        pos = epos;
        play_hold = HOLD_END;
      end
    end
    if ((seg == bseg && pos <= bpos) || seg < bseg) begin
      if (r.loop_on) begin
        seg = eseg;
        pos = pos - bpos + epos;
      end else begin
        seg = bseg;
        pos = bpos;
        play_hold = HOLD_BEGIN;
      end
    end
    if (pos < 0) pos = 0;
    if (pos > 64'hFFFF_FFFF) pos = 64'hFFFF_FFFF;
    if (seg < 0) seg = 0;
    if (seg > TOP_SEG) seg = TOP_SEG;
    play_seg = 8'(seg);
    play_pos = 32'(pos);
    return o;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        frames_due.push_back(advance_phasor(req));
      end
      if (!req_valid || !req_stall) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= sample_queue.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (rsp_valid && !rsp_stall) begin
        if (frames_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatch_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("even_segment", want.even_segment, rsp.even_segment);
          check_field("even_position", want.even_position, rsp.even_position);
          check_field("odd_segment", want.odd_segment, rsp.odd_segment);
          check_field("odd_position", want.odd_position, rsp.odd_position);
          check_field("crossfade", $signed(want.crossfade), $signed(rsp.crossfade));
          check_field("is_running", want.is_running, rsp.is_running);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cfg_t make_cfg(input logic [23:0] ov, input logic [7:0] bs,
                                    input logic [31:0] bp, input logic [7:0] es,
                                    input logic [31:0] ep);
    cfg_t c;
    c.overlap_len = ov;
    c.begin_segment = bs;
    c.begin_position = bp;
    c.end_segment = es;
    c.end_position = ep;
    return c;
  endfunction

  function automatic logic [31:0] fit_pos(input longint p);
    if (p < 0) return '0;
    if (p > 64'hFFFF_FFFF) return '1;
    return 32'(p);
  endfunction

  task automatic add_req(input logic trig, input logic [23:0] rate, input logic [7:0] sseg,
                         input logic [31:0] spos, input logic wrap_on);
    req_t r;
    r.trig_high = trig;
    r.step_rate = rate;
    r.start_segment = sseg;
    r.start_position = spos;
    r.loop_on = wrap_on;
    sample_queue.push_back(r);
    queued_items++;
  endtask

  task automatic add_noise(input int len);
    for (int i = 0; i < len; i++) begin
      add_req(1'($urandom), 24'($urandom), 8'($urandom), $urandom, 1'($urandom));
    end
  endtask

  // A run is a trigger edge aimed at a bound, a segment carry or the overlap,
  // followed by steady play with occasional rate reversals and dropouts.
  task automatic add_run(input int len);
    logic signed [23:0] rate;
    logic wrap_on;
    longint span, aim;
    logic [7:0] aim_seg;
    span = (SEG_LEN - longint'(regs.overlap_len)) <<< 8;
    case ($urandom_range(4))
      0: rate = 24'($urandom);
      1: rate = 24'($signed(17'($urandom)));
      2: rate = 24'($signed(13'($urandom)));
      3: rate = 24'($signed(10'($urandom)));
      default: rate = '0;
    endcase
    aim_seg = 8'($urandom);
    case ($urandom_range(5))
      0: begin
        aim_seg = regs.end_segment;
        aim = longint'(regs.end_position) - longint'($urandom_range(1 << 20));
      end
      1: begin
        aim_seg = regs.begin_segment;
        aim = longint'(regs.begin_position) + longint'($urandom_range(1 << 20));
      end
      2: aim = span - longint'($urandom_range(1 << 20));
      3: aim = longint'($urandom_range(1 << 20));
      4: aim = longint'($urandom_range(32'(regs.overlap_len) << 8));
      default: aim = longint'($urandom);
    endcase
    wrap_on = 1'($urandom);
    add_req(1'b0, 24'($urandom), 8'($urandom), $urandom, wrap_on);
    add_req(1'b1, rate, aim_seg, fit_pos(aim), wrap_on);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) rate = -rate;
      if ($urandom_range(19) == 0) wrap_on = !wrap_on;
      add_req($urandom_range(19) != 0,
              ($urandom_range(19) == 0) ? 24'($urandom) : rate,
              8'($urandom), $urandom, wrap_on);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_queue.size() != 0 || req_valid || frames_due.size() != 0);
  endtask

  task automatic write_registers(input cfg_t c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OVERLAP_LEN;
    cfg_data <= 32'(c.overlap_len);
    @(posedge clk);
    cfg_index <= CFG_BEGIN_SEGMENT;
    cfg_data <= 32'(c.begin_segment);
    @(posedge clk);
    cfg_index <= CFG_BEGIN_POSITION;
    cfg_data <= c.begin_position;
    @(posedge clk);
    cfg_index <= CFG_END_SEGMENT;
    cfg_data <= 32'(c.end_segment);
    @(posedge clk);
    cfg_index <= CFG_END_POSITION;
    cfg_data <= c.end_position;
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = c;
  endtask

  initial begin
    cfg_t plan [8];
    int send_mode [4];
    int recv_mode [4];
    int base;
    logic [7:0] lo_seg;
    send_mode = '{0, 87, 0, 34};
    recv_mode = '{0, 0, 87, 34};
    regs = make_cfg(24'd0, 8'd0, 32'd0, 8'd255, 32'd0);

    lo_seg = 8'($urandom);
    plan[0] = make_cfg(24'd256, 8'd1, 32'h80, 8'd4, 32'h4000_0000);
    plan[1] = make_cfg(24'd1, 8'd0, 32'd0, 8'd255, 32'hFFFF_FFFF);
    plan[2] = make_cfg(24'hFF_FFFF, 8'd255, 32'hFFFF_FFFF, 8'd0, 32'd0);
    plan[3] = make_cfg(24'd2, 8'd10, 32'h100, 8'd12, 32'h200);
    plan[4] = make_cfg(24'd0, 8'd0, 32'd0, 8'd255, 32'd0);
    plan[5] = make_cfg(24'($urandom_range(1 << 20)), lo_seg, $urandom,
                       (lo_seg > 8'd252) ? 8'd255 : lo_seg + 8'($urandom_range(3)),
                       $urandom);
    plan[6] = make_cfg(24'($urandom), 8'($urandom), $urandom, 8'($urandom), $urandom);
    plan[7] = make_cfg(24'h80_0000, 8'd2, $urandom, 8'd3, $urandom);

    // Reset settings: idle channel, hold at the lower bound, wrap at the top.
    add_req(1'b0, 24'd0, 8'd0, 32'd0, 1'b0);
    add_req(1'b0, 24'hFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    add_req(1'b1, 24'h7F_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    add_req(1'b1, 24'h80_0000, 8'h00, 32'h0000_0000, 1'b1);
    add_req(1'b0, 24'h7F_FFFF, 8'h00, 32'h0000_0000, 1'b0);
    add_req(1'b1, 24'h00_0100, 8'h80, 32'h8000_0000, 1'b0);
    add_req(1'b1, 24'd0, 8'd0, 32'd0, 1'b1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      repeat (30) @(posedge clk);
      write_registers(plan[ph]);
      @(negedge clk);
      send_idle_pct = send_mode[ph % 4];
      recv_stall_pct = recv_mode[ph % 4];
      if (ph == 0) begin
        // Crossfade ramp on even and odd segments, segment zero, clamping and
        // release at both bounds, and wrapping past either bound.
        add_req(1'b0, 24'd0, 8'd0, 32'd0, 1'b0);
        add_req(1'b1, 24'h00_0100, 8'd2, 32'd0, 1'b0);
        add_req(1'b1, 24'h00_0100, 8'd0, 32'd0, 1'b0);
        add_req(1'b0, 24'h00_7F80, 8'd0, 32'd0, 1'b0);
        add_req(1'b1, 24'd0, 8'd3, 32'h0000_FF00, 1'b0);
        add_req(1'b0, 24'd0, 8'd0, 32'd0, 1'b0);
        add_req(1'b1, 24'hFF_FF00, 8'd0, 32'h10, 1'b1);
        add_req(1'b0, 24'h7F_FFFF, 8'd0, 32'd0, 1'b0);
        add_req(1'b1, 24'h7F_FFFF, 8'd4, 32'h3FFF_0000, 1'b0);
        add_req(1'b1, 24'h7F_FFFF, 8'd0, 32'd0, 1'b0);
        add_req(1'b1, 24'hFF_F000, 8'd0, 32'd0, 1'b0);
        add_req(1'b0, 24'd0, 8'd0, 32'd0, 1'b0);
        add_req(1'b1, 24'h80_0000, 8'd1, 32'h0000_0100, 1'b0);
        add_req(1'b1, 24'h00_0001, 8'd0, 32'd0, 1'b0);
        add_req(1'b0, 24'd0, 8'd0, 32'd0, 1'b1);
        add_req(1'b1, 24'h7F_FFFF, 8'd200, 32'hFFFF_FFF0, 1'b1);
      end
      for (int half = 0; half < 2; half++) begin
        if (half == 1) wait_drained();
        base = queued_items;
        while (queued_items - base < 100) begin
          if ($urandom_range(6) == 0) begin
            add_noise($urandom_range(1, 4));
          end else begin
            add_run($urandom_range(3, 40));
          end
        end
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> segmented_phasor_crossfade.f
hw/rtl/spc_pkg.sv
hw/rtl/spc_ctrl.sv
hw/rtl/spc_dpath.sv
hw/rtl/segmented_phasor_crossfade.sv
sim/segmented_phasor_crossfade_tb.sv
